@@ rtl/intfmt_pkg.sv @@
// Package for the integer field formatter: state and segment codes, ASCII
// constants and the digit-to-character function. No dependencies.
`default_nettype none

package intfmt_pkg;

   // Controller states, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CONV = 5'b00010,
      ST_SIZE = 5'b00100,
      ST_PLAN = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   // Format modes as carried on the request.
   localparam logic [2:0] MODE_SDEC = 3'd0;
   localparam logic [2:0] MODE_UDEC = 3'd1;
   localparam logic [2:0] MODE_HEXL = 3'd2;
   localparam logic [2:0] MODE_HEXU = 3'd3;
   localparam logic [2:0] MODE_CHAR = 3'd4;

   // Output segments, emitted in this order.
   typedef logic [2:0] seg_type;
   localparam seg_type SEG_LEAD  = 3'd0;
   localparam seg_type SEG_SIGN  = 3'd1;
   localparam seg_type SEG_PRE   = 3'd2;
   localparam seg_type SEG_ZPAD  = 3'd3;
   localparam seg_type SEG_PREC  = 3'd4;
   localparam seg_type SEG_DIG   = 3'd5;
   localparam seg_type SEG_TRAIL = 3'd6;
   localparam int      SEG_COUNT = 7;

   // Decimal digits held in BCD and hex digits held as nibbles.
   localparam int DIGITS    = 10;
   localparam int VALUE_W   = 32;
   localparam int BIT_CNT_W = 5;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_UA    = 8'h41;

   function automatic logic [7:0] nibble_char(input logic [3:0] nib, input logic upper);
      logic [7:0] base;
      base = upper ? CH_UA : CH_LA;
      if (nib < 4'd10) begin
         nibble_char = CH_ZERO + {4'd0, nib};
      end else begin
         nibble_char = base + {4'd0, nib - 4'd10};
      end
   endfunction

endpackage

`default_nettype wire

@@ rtl/integer_field_formatter_core.sv @@
// Top level of the integer field formatter: formats one 32-bit operand as a
// printf-style field and streams it out one character per cycle, pausing at segment steps.
// Depends on intfmt_pkg.
//
//   channel   ports                                    handshake
//   --------  ---------------------------------------  -------------------------------
//   request   start, busy, req_*                       taken when start high, busy low
//   result    rsp_valid, rsp_out_char, rsp_last_char   one-cycle strobe, always taken
//
// Decimal requests pass through the bit-serial binary-to-BCD converter; hex and
// character requests skip it. Sizing runs through the SIZE and PLAN states, then EMIT
// sends the characters and steps across the seven segments, with no output on a step.
// A synchronous reset returns the controller to idle. The receiver cannot stall, and
// busy drops as the final character reaches the result ports.
`default_nettype none

module integer_field_formatter_core #(
   parameter int MAX_FIELD = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_mode,
   input  wire logic [31:0] req_value,
   input  wire logic        req_left_justify,
   input  wire logic        req_zero_fill,
   input  wire logic        req_force_plus,
   input  wire logic        req_space_sign,
   input  wire logic        req_alt_form,
   input  wire logic [6:0]  req_field_width,
   input  wire logic        req_precision_given,
   input  wire logic [5:0]  req_precision_digits,
   output logic             rsp_valid,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_last_char
);

   import intfmt_pkg::*;

   // Counters are sized to hold the longest field.
   localparam int CNT_W = $clog2(MAX_FIELD + 1);
   localparam logic [CNT_W-1:0] WIDTH_MAX = CNT_W'(MAX_FIELD);
   localparam logic [CNT_W-1:0] PREC_MAX  = CNT_W'(MAX_FIELD - 2);

   state_type state_ff, state_in;

   // Request fields held for the whole formatting run.
   logic             is_char_ff, is_char_in;
   logic             upper_ff, upper_in;
   logic             minus_ff, minus_in;
   logic             zpad_ff, zpad_in;
   logic             has_prec_ff, has_prec_in;
   logic             has_sign_ff, has_sign_in;
   logic             has_pre_ff, has_pre_in;
   logic [7:0]       sign_char_ff, sign_char_in;
   logic [7:0]       raw_char_ff, raw_char_in;
   logic [CNT_W-1:0] width_ff, width_in;
   logic [CNT_W-1:0] prec_ff, prec_in;

   // Bit-serial converter: magnitude shifts out at the top, BCD fills in.
   logic [VALUE_W-1:0]   mag_ff, mag_in;
   logic [4*DIGITS-1:0]  bcd_ff, bcd_in;
   logic [4*DIGITS-1:0]  bcd_adj;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;

   // Field sizing.
   logic [3:0]       ndig_ff, ndig_in;
   logic [CNT_W-1:0] prec_zeros_ff, prec_zeros_in;
   logic [CNT_W-1:0] content_ff, content_in;
   logic [3:0]       ndig_scan;
   logic [CNT_W-1:0] pad;

   // Emission: one character count per segment and a total for the last flag.
   logic [CNT_W-1:0] cnt_ff [SEG_COUNT];
   logic [CNT_W-1:0] cnt_in [SEG_COUNT];
   seg_type          cur_ff, cur_in;
   logic [CNT_W-1:0] remain_ff, remain_in;

   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;

   logic [3:0] dig_idx;
   logic [3:0] dig_nib;
   logic [7:0] seg_char;
   logic [VALUE_W-1:0] neg_value;

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = valid_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_last_char = last_ff;

   assign neg_value = VALUE_W'(0) - req_value;

   // Shift-add-3 correction, applied to each BCD digit independently.
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // Count of significant digits, at least one.
   always_comb begin
      ndig_scan = 4'd1;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            ndig_scan = 4'(i + 1);
         end
      end
   end

   assign pad = (width_ff > content_ff) ? (width_ff - content_ff) : '0;

   // Digits leave most significant first: the digit count walks down the index.
   assign dig_idx = 4'(cnt_ff[SEG_DIG] - CNT_W'(1));

   always_comb begin
      dig_nib = 4'd0;
      for (int i = 0; i < DIGITS; i++) begin
         if (dig_idx == 4'(i)) begin
            dig_nib = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      case (cur_ff)
         SEG_LEAD:  seg_char = CH_SPACE;
         SEG_SIGN:  seg_char = sign_char_ff;
         SEG_PRE: begin
            if (cnt_ff[SEG_PRE] == CNT_W'(2)) begin
               seg_char = CH_ZERO;
            end else begin
               seg_char = upper_ff ? CH_UX : CH_LX;
            end
         end
         SEG_ZPAD:  seg_char = CH_ZERO;
         SEG_PREC:  seg_char = CH_ZERO;
         SEG_DIG:   seg_char = is_char_ff ? raw_char_ff : nibble_char(dig_nib, upper_ff);
         SEG_TRAIL: seg_char = CH_SPACE;
         default:   seg_char = CH_SPACE;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      is_char_in    = is_char_ff;
      upper_in      = upper_ff;
      minus_in      = minus_ff;
      zpad_in       = zpad_ff;
      has_prec_in   = has_prec_ff;
      has_sign_in   = has_sign_ff;
      has_pre_in    = has_pre_ff;
      sign_char_in  = sign_char_ff;
      raw_char_in   = raw_char_ff;
      width_in      = width_ff;
      prec_in       = prec_ff;
      mag_in        = mag_ff;
      bcd_in        = bcd_ff;
      bit_cnt_in    = bit_cnt_ff;
      ndig_in       = ndig_ff;
      prec_zeros_in = prec_zeros_ff;
      content_in    = content_ff;
      cnt_in        = cnt_ff;
      cur_in        = cur_ff;
      remain_in     = remain_ff;
      valid_in      = 1'b0;
      char_in       = char_ff;
      last_in       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // Modes five to seven fall through to unsigned decimal.
               is_char_in  = (req_mode == MODE_CHAR);
               upper_in    = (req_mode == MODE_HEXU);
               minus_in    = req_left_justify;
               // Minus cancels zero; a precision or character mode disables it too.
               zpad_in     = !req_left_justify && req_zero_fill && !req_precision_given
                             && (req_mode != MODE_CHAR);
               has_prec_in = req_precision_given && (req_mode != MODE_CHAR);
               raw_char_in = req_value[7:0];
               width_in    = (req_field_width > 7'(MAX_FIELD)) ? WIDTH_MAX
                                                               : CNT_W'(req_field_width);
               prec_in     = (req_precision_digits > 6'(MAX_FIELD - 2)) ? PREC_MAX
                                                               : CNT_W'(req_precision_digits);
               has_pre_in  = req_alt_form && (req_value != '0)
                             && ((req_mode == MODE_HEXL) || (req_mode == MODE_HEXU));
               // Sign priority: negative, then plus, then space.
               has_sign_in  = 1'b0;
               sign_char_in = CH_SPACE;
               mag_in       = req_value;
               if (req_mode == MODE_SDEC) begin
                  if (req_value[VALUE_W-1]) begin
                     has_sign_in  = 1'b1;
                     sign_char_in = CH_MINUS;
                     mag_in       = neg_value;
                  end else if (req_force_plus) begin
                     has_sign_in  = 1'b1;
                     sign_char_in = CH_PLUS;
                  end else if (req_space_sign) begin
                     has_sign_in  = 1'b1;
                  end
               end
               bit_cnt_in = '0;
               if ((req_mode == MODE_HEXL) || (req_mode == MODE_HEXU)
                   || (req_mode == MODE_CHAR)) begin
                  bcd_in   = {8'd0, req_value};
                  state_in = ST_SIZE;
               end else begin
                  bcd_in   = '0;
                  state_in = ST_CONV;
               end
            end
         end

         ST_CONV: begin
            bcd_in     = {bcd_adj[4*DIGITS-2:0], mag_ff[VALUE_W-1]};
            mag_in     = {mag_ff[VALUE_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_CNT_W'(VALUE_W - 1)) begin
               state_in = ST_SIZE;
            end
         end

         ST_SIZE: begin
            if (is_char_ff) begin
               ndig_in       = 4'd1;
               prec_zeros_in = '0;
               content_in    = CNT_W'(1);
            end else begin
               ndig_in = ndig_scan;
               if (has_prec_ff && (prec_ff > CNT_W'(ndig_scan))) begin
                  prec_zeros_in = prec_ff - CNT_W'(ndig_scan);
               end else begin
                  prec_zeros_in = '0;
               end
               content_in = CNT_W'(has_sign_ff) + (has_pre_ff ? CNT_W'(2) : CNT_W'(0))
                            + prec_zeros_in + CNT_W'(ndig_scan);
            end
            state_in = ST_PLAN;
         end

         ST_PLAN: begin
            cnt_in[SEG_LEAD]  = (!minus_ff && !zpad_ff) ? pad : '0;
            cnt_in[SEG_SIGN]  = (has_sign_ff && !is_char_ff) ? CNT_W'(1) : '0;
            cnt_in[SEG_PRE]   = has_pre_ff ? CNT_W'(2) : '0;
            cnt_in[SEG_ZPAD]  = zpad_ff ? pad : '0;
            cnt_in[SEG_PREC]  = prec_zeros_ff;
            cnt_in[SEG_DIG]   = CNT_W'(ndig_ff);
            cnt_in[SEG_TRAIL] = minus_ff ? pad : '0;
            cur_in            = SEG_LEAD;
            remain_in         = content_ff + pad;
            state_in          = ST_EMIT;
         end

         ST_EMIT: begin
            if (cnt_ff[cur_ff] != '0) begin
               cnt_in[cur_ff] = cnt_ff[cur_ff] - CNT_W'(1);
               remain_in      = remain_ff - CNT_W'(1);
               valid_in       = 1'b1;
               char_in        = seg_char;
               if (remain_ff == CNT_W'(1)) begin
                  last_in  = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (cur_ff != SEG_TRAIL) begin
               // Empty segment: step to the next one without output.
               cur_in = cur_ff + seg_type'(1);
            end else begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      is_char_ff    <= is_char_in;
      upper_ff      <= upper_in;
      minus_ff      <= minus_in;
      zpad_ff       <= zpad_in;
      has_prec_ff   <= has_prec_in;
      has_sign_ff   <= has_sign_in;
      has_pre_ff    <= has_pre_in;
      sign_char_ff  <= sign_char_in;
      raw_char_ff   <= raw_char_in;
      width_ff      <= width_in;
      prec_ff       <= prec_in;
      mag_ff        <= mag_in;
      bcd_ff        <= bcd_in;
      bit_cnt_ff    <= bit_cnt_in;
      ndig_ff       <= ndig_in;
      prec_zeros_ff <= prec_zeros_in;
      content_ff    <= content_in;
      cnt_ff        <= cnt_in;
      cur_ff        <= cur_in;
      remain_ff     <= remain_in;
      char_ff       <= char_in;
   end

endmodule

`default_nettype wire
